// ----- rtl/tsc_pkg.sv -----
package tsc_pkg;

    // Field widths fixed by the event and gesture formats.
    localparam int KIND_BITS    = 3;
    localparam int COORD_BITS   = 12;
    localparam int GESTURE_BITS = 3;
    localparam int CFG_IDX_BITS = 2;

    // Raw touch panel spans used in scaled mode.
    localparam int RAW_X_SPAN   = 1024;
    localparam int RAW_X_SHIFT  = 10;
    localparam int RAW_Y_SPAN   = 600;

    // Y scaling: floor(v * h / 600) == (v * h * Y_RECIP) >> Y_SHIFT for v < 600, h < 4096.
    // Y_RECIP is the ceiling of 2**31 / 600; the rounding error stays below 1/600.
    localparam int Y_SHIFT      = 31;
    localparam int YK_BITS      = 34;
    localparam logic [21:0] Y_RECIP = 22'd3579140;

    // Event kinds.
    localparam logic [KIND_BITS-1:0] KIND_OTHER = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_X     = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_Y     = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_BTN   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_ERR   = 3'd4;

    // Gesture codes.
    localparam logic [GESTURE_BITS-1:0] G_NONE  = 3'd0;
    localparam logic [GESTURE_BITS-1:0] G_TAP   = 3'd1;
    localparam logic [GESTURE_BITS-1:0] G_LEFT  = 3'd2;
    localparam logic [GESTURE_BITS-1:0] G_RIGHT = 3'd3;
    localparam logic [GESTURE_BITS-1:0] G_UP    = 3'd4;
    localparam logic [GESTURE_BITS-1:0] G_DOWN  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALED    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd3;

    // Configuration reset values.
    localparam logic [COORD_BITS-1:0] WIDTH_RESET     = 12'd800;
    localparam logic [COORD_BITS-1:0] HEIGHT_RESET    = 12'd480;
    localparam logic [COORD_BITS-1:0] THRESHOLD_RESET = 12'd50;
    localparam logic [YK_BITS-1:0]    YK_RESET        = YK_BITS'(64'd480 * 64'd3579140);

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [COORD_BITS-1:0] value;
    } t_tsc_in;

    typedef struct packed {
        logic [GESTURE_BITS-1:0] gesture;
        logic [COORD_BITS-1:0]   tap_x;
        logic [COORD_BITS-1:0]   tap_y;
    } t_tsc_out;

endpackage

// ----- rtl/touch_swipe_classifier.sv -----
// Touch swipe classifier. Takes one touch event per clock (X, Y, button, read error or
// other) and reports a tap with its start point, or a left, right, up or down swipe, when
// the touch is released. A gesture is loaded into the output register once the release
// event has passed the first stage; events that cause no gesture produce nothing.
// The first stage registers the event together with its scaled position (the Y scaling
// multiplier sets that path); the second updates the start and end points and classifies.
// A new event is taken every cycle unless a finished gesture is held by output stall while
// another event waits in the first stage. The configuration port is always ready.
module touch_swipe_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tsc_pkg::t_tsc_in                    i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tsc_pkg::t_tsc_out                   o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tsc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [tsc_pkg::COORD_BITS-1:0]      i_cfg_data
);
    import tsc_pkg::*;

    // Configuration registers; r_yk holds screen_height times the Y reciprocal.
    logic                  r_scaled;
    logic [COORD_BITS-1:0] r_width;
    logic [COORD_BITS-1:0] r_height;
    logic [COORD_BITS-1:0] r_thresh;
    logic [YK_BITS-1:0]    r_yk;

    // First stage: registered event with its converted position.
    logic                  r_s1_vld;
    logic [KIND_BITS-1:0]  r_s1_kind;
    logic                  r_s1_vzero;
    logic                  r_s1_okx;
    logic                  r_s1_oky;
    logic [COORD_BITS-1:0] r_s1_px;
    logic [COORD_BITS-1:0] r_s1_py;

    // Gesture state.
    logic                  r_track;
    logic [COORD_BITS-1:0] r_sx;
    logic [COORD_BITS-1:0] r_sy;
    logic [COORD_BITS-1:0] r_ex;
    logic [COORD_BITS-1:0] r_ey;
    logic                  n_track;
    logic [COORD_BITS-1:0] n_sx;
    logic [COORD_BITS-1:0] n_sy;
    logic [COORD_BITS-1:0] n_ex;
    logic [COORD_BITS-1:0] n_ey;

    // Output register.
    logic                  r_out_vld;
    t_tsc_out              r_out;
    t_tsc_out              n_out;
    logic                  emit;

    // Handshake and stage movement.
    logic                  in_xfer;
    logic                  out_free;
    logic                  s1_go;
    logic                  cfg_xfer;

    // Position conversion.
    logic [21:0]                 prod_x;
    logic [RAW_X_SHIFT+YK_BITS-1:0] prod_y;
    logic [COORD_BITS-1:0]       conv_x;
    logic [COORD_BITS-1:0]       conv_y;
    logic                        rng_x;
    logic                        rng_y;

    // Classification.
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [GESTURE_BITS-1:0] gest;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign s1_go       = r_s1_vld && out_free;
    assign o_in_stall  = r_s1_vld && !out_free;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // Configuration writes; the Y scale factor is formed as screen_height is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaled <= 1'b0;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_thresh <= THRESHOLD_RESET;
            r_yk     <= YK_RESET;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                CFG_SCALED:    r_scaled <= i_cfg_data[0];
                CFG_WIDTH:     r_width  <= i_cfg_data;
                CFG_HEIGHT: begin
                    r_height <= i_cfg_data;
                    r_yk     <= YK_BITS'(i_cfg_data) * YK_BITS'(Y_RECIP);
                end
                CFG_THRESHOLD: r_thresh <= i_cfg_data;
                default:       r_scaled <= r_scaled;
            endcase
        end
    end

    // Range check and scaling of the incoming position value.
    always_comb begin
        prod_x = 22'(i_in.value[RAW_X_SHIFT-1:0]) * 22'(r_width);
        prod_y = (RAW_X_SHIFT+YK_BITS)'(i_in.value[RAW_X_SHIFT-1:0])
                 * (RAW_X_SHIFT+YK_BITS)'(r_yk);
        if (r_scaled) begin
            rng_x  = i_in.value < COORD_BITS'(RAW_X_SPAN);
            rng_y  = i_in.value < COORD_BITS'(RAW_Y_SPAN);
            conv_x = prod_x[RAW_X_SHIFT +: COORD_BITS];
            conv_y = prod_y[Y_SHIFT +: COORD_BITS];
        end else begin
            rng_x  = i_in.value < r_width;
            rng_y  = i_in.value < r_height;
            conv_x = i_in.value;
            conv_y = i_in.value;
        end
    end

    // First stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_kind  <= i_in.kind;
            r_s1_vzero <= i_in.value == '0;
            r_s1_okx   <= (i_in.kind == KIND_X) && rng_x;
            r_s1_oky   <= (i_in.kind == KIND_Y) && rng_y;
            r_s1_px    <= conv_x;
            r_s1_py    <= conv_y;
        end
    end

    // Displacements from the start point to the current end point.
    always_comb begin
        ax = (r_ex > r_sx) ? r_ex - r_sx : r_sx - r_ex;
        ay = (r_ey > r_sy) ? r_ey - r_sy : r_sy - r_ey;
        // A release with no clear move is a tap; otherwise the larger axis wins and
        // a tie goes to the vertical axis.
        priority if ((r_ex == '0 && r_ey == '0) || (ax <= r_thresh && ay <= r_thresh)) begin
            gest = G_TAP;
        end else if (ax > ay) begin
            gest = (r_ex > r_sx) ? G_RIGHT : G_LEFT;
        end else begin
            gest = (r_sy > r_ey) ? G_UP : G_DOWN;
        end
    end

    // Point tracking and gesture emission for the event in the first stage.
    always_comb begin
        n_track = r_track;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_ex    = r_ex;
        n_ey    = r_ey;
        emit    = 1'b0;
        n_out   = '0;
        priority if (r_s1_kind == KIND_ERR) begin
            n_track = 1'b0;
            n_sx    = '0;
            n_sy    = '0;
            n_ex    = '0;
            n_ey    = '0;
        end else if (!r_track) begin
            if (r_s1_okx && !r_s1_vzero) begin
                n_sx = r_s1_px;
            end
            if (r_s1_oky && !r_s1_vzero) begin
                n_sy = r_s1_py;
            end
            if (n_sx != '0 && n_sy != '0) begin
                n_track = 1'b1;
                n_ex    = '0;
                n_ey    = '0;
            end
        end else if (r_s1_kind == KIND_BTN && r_s1_vzero) begin
            emit          = 1'b1;
            n_out.gesture = gest;
            if (gest == G_TAP) begin
                n_out.tap_x = r_sx;
                n_out.tap_y = r_sy;
            end
            n_track = 1'b0;
            n_sx    = '0;
            n_sy    = '0;
            n_ex    = '0;
            n_ey    = '0;
        end else begin
            if (r_s1_okx) begin
                n_ex = r_s1_px;
            end
            if (r_s1_oky) begin
                n_ey = r_s1_py;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= 1'b0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_ex    <= '0;
            r_ey    <= '0;
        end else if (s1_go) begin
            r_track <= n_track;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_ex    <= n_ex;
            r_ey    <= n_ey;
        end
    end

    // Output register: loaded on a gesture, freed when the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go && emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && emit) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    // A delivered gesture is always a real one.
    a_gesture_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.gesture != G_NONE)
        else $error("gesture output carries no gesture");

    // Only a tap carries a start point.
    a_swipe_no_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.gesture != G_TAP) |-> (o_out.tap_x == '0 && o_out.tap_y == '0))
        else $error("swipe carries a tap point");

    // Tracking is entered only with both start coordinates set.
    a_track_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_track |-> (r_sx != '0 && r_sy != '0))
        else $error("tracking without a start point");

    // A read error drops back to capture.
    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_kind == KIND_ERR) |=> (!r_track && r_sx == '0 && r_sy == '0))
        else $error("read error did not clear the points");
`endif

endmodule
